// ----- rtl/core/posit_multiplier_top_defines.svh -----
// Assertion macros shared by the posit multiplier RTL.
`ifndef POSIT_MULTIPLIER_TOP_DEFINES_SVH
`define POSIT_MULTIPLIER_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/pm_pkg.sv -----
// Types, constants and register codes of the posit multiplier.
package pm_pkg;

  localparam int PM_W              = 32;
  localparam int SCALE_W           = 12;
  localparam int REG_W             = 7;
  localparam int MAX_WORD_BITS_DEF = 32;
  localparam int CFG_IDX_W         = 1;
  localparam int CFG_DATA_W        = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_BITS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_BITS  = 1'd1;

  localparam logic [5:0] WORD_BITS_RST = 6'd16;
  localparam logic [2:0] EXP_BITS_RST  = 3'd1;

  // Left aligned special posit patterns.
  localparam logic [PM_W-1:0] PM_INF  = 32'h8000_0000;
  localparam logic [PM_W-1:0] PM_ONE  = 32'h4000_0000;
  localparam logic [PM_W-1:0] PM_MONE = 32'hC000_0000;

  typedef struct packed {
    logic [5:0] n;
    logic [2:0] es;
  } pm_cfg_t;

  typedef struct packed {
    logic            hit;
    logic            invalid;
    logic [PM_W-1:0] r;
  } pm_special_t;

  typedef struct packed {
    logic signed [SCALE_W-1:0] scale;
    logic [PM_W-1:0]           frac;
  } pm_half_t;

  typedef struct packed {
    pm_cfg_t         cfg;
    pm_special_t     spec;
    logic            neg;
    logic [PM_W-1:0] ma;
    logic [PM_W-1:0] mb;
  } pm_dec_t;

  typedef struct packed {
    pm_cfg_t                   cfg;
    pm_special_t               spec;
    logic                      neg;
    logic signed [SCALE_W-1:0] sa;
    logic signed [SCALE_W-1:0] sb;
    logic [PM_W-1:0]           fa;
    logic [PM_W-1:0]           fb;
  } pm_unp_t;

  typedef struct packed {
    pm_cfg_t                   cfg;
    pm_special_t               spec;
    logic                      neg;
    logic signed [SCALE_W-1:0] raw1;
    logic [PM_W-1:0]           m;
  } pm_prod_t;

  typedef struct packed {
    pm_cfg_t                 cfg;
    pm_special_t             spec;
    logic                    neg;
    logic signed [REG_W-1:0] rreg;
    logic [3:0]              rexp;
    logic [PM_W-1:0]         rfrac;
  } pm_fmt_t;

endpackage

// ----- rtl/core/pm_if.sv -----
// Stream interfaces for operand beats and product beats.
interface pm_in_if;
  import pm_pkg::*;
  logic            valid;
  logic            ready;
  logic [PM_W-1:0] operand_a;
  logic [PM_W-1:0] operand_b;
  modport source (output valid, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input operand_a, input operand_b, output ready);
endinterface

interface pm_out_if;
  import pm_pkg::*;
  logic            valid;
  logic            ready;
  logic [PM_W-1:0] product;
  logic            invalid;
  modport source (output valid, output product, output invalid, input ready);
  modport sink   (input valid, input product, input invalid, output ready);
endinterface

// ----- rtl/core/pm_unpack.sv -----
// Operand alignment, special case detection and posit field decode (two stages).
module pm_unpack #(
  parameter int MAX_WORD_BITS = pm_pkg::MAX_WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [5:0]           word_bits,
  input  logic [2:0]           exp_bits,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          operand_a,
  input  logic [31:0]          operand_b,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pm_pkg::pm_unp_t      out_data
);
  import pm_pkg::*;

  localparam int LIM = (MAX_WORD_BITS < PM_W) ? MAX_WORD_BITS : PM_W;

  // Splits a nonzero left aligned magnitude into scale and fraction.
  function automatic pm_half_t decode_mag(input logic [PM_W-1:0] u,
                                          input logic [5:0] n,
                                          input logic [2:0] es);
    logic [PM_W-1:0]           body;
    logic [PM_W-1:0]           x;
    logic                      first;
    logic [5:0]                lz;
    logic [5:0]                run;
    logic [5:0]                rs;
    logic [5:0]                sh;
    logic signed [REG_W-1:0]   rg;
    logic [PM_W-1:0]           w;
    logic [PM_W-1:0]           ex;
    logic signed [SCALE_W-1:0] scl;
    pm_half_t                  res;
    body  = u << 1;
    first = body[PM_W-1];
    x     = first ? ~body : body;
    lz    = 6'd32;
    for (int i = 0; i < PM_W; i++) begin
      if (x[i]) lz = 6'(PM_W - 1 - i);
    end
    run = (lz < n - 6'd1) ? lz : n - 6'd1;
    rg  = first ? ($signed({1'b0, run}) - 7'sd1) : -$signed({1'b0, run});
    rs  = (run + 6'd1 < n - 6'd1) ? run + 6'd1 : n - 6'd1;
    w   = u << (rs + 6'd1);
    ex  = w >> (6'd32 - {3'b000, es});
    sh  = 6'd1 + rs + {3'b000, es};
    scl = SCALE_W'(rg);
    res.scale = (scl <<< es) + $signed({{(SCALE_W-4){1'b0}}, ex[3:0]});
    res.frac  = u << sh;
    return res;
  endfunction

  // Stage one: effective format, alignment, special cases and magnitudes.
  pm_cfg_t         cfg;
  logic [PM_W-1:0] low;
  logic [PM_W-1:0] top;
  logic [PM_W-1:0] a;
  logic [PM_W-1:0] b;
  logic [5:0]      sh_l;
  pm_dec_t         s1_nxt;
  pm_dec_t         s1_r;
  logic            s1_v_r;
  logic            adv1;
  logic            adv2;

  always_comb begin
    if (word_bits < 6'd3) begin
      cfg.n = 6'd3;
    end else if (word_bits > 6'(LIM)) begin
      cfg.n = 6'(LIM);
    end else begin
      cfg.n = word_bits;
    end
    cfg.es = (exp_bits > 3'd4) ? 3'd4 : exp_bits;
    sh_l   = 6'd32 - cfg.n;
    low    = ~(32'hFFFF_FFFF << cfg.n);
    top    = 32'hFFFF_FFFF << sh_l;
    a      = (operand_a & low) << sh_l;
    b      = (operand_b & low) << sh_l;

    s1_nxt.cfg          = cfg;
    s1_nxt.spec.hit     = 1'b1;
    s1_nxt.spec.invalid = 1'b0;
    s1_nxt.spec.r       = '0;
    if (a == '0) begin
      s1_nxt.spec.invalid = (b == PM_INF);
    end else if (b == '0) begin
      s1_nxt.spec.invalid = (a == PM_INF);
    end else if (a == PM_ONE || a == PM_MONE) begin
      s1_nxt.spec.r = (a == PM_MONE) ? ((32'd0 - b) & top) : b;
    end else if (b == PM_ONE || b == PM_MONE) begin
      s1_nxt.spec.r = (b == PM_MONE) ? ((32'd0 - a) & top) : a;
    end else if (a == PM_INF || b == PM_INF) begin
      s1_nxt.spec.r = PM_INF;
    end else begin
      s1_nxt.spec.hit = 1'b0;
    end
    s1_nxt.neg = a[PM_W-1] ^ b[PM_W-1];
    s1_nxt.ma  = a[PM_W-1] ? ((32'd0 - a) & top) : a;
    s1_nxt.mb  = b[PM_W-1] ? ((32'd0 - b) & top) : b;
  end

  assign adv1     = !s1_v_r || adv2;
  assign in_ready = adv1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (adv1) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && in_valid) begin
      s1_r <= s1_nxt;
    end
  end

  // Stage two: regime run length, exponent and fraction of both operands.
  pm_half_t ha;
  pm_half_t hb;
  pm_unp_t  s2_nxt;
  pm_unp_t  s2_r;
  logic     s2_v_r;

  always_comb begin
    ha          = decode_mag(s1_r.ma, s1_r.cfg.n, s1_r.cfg.es);
    hb          = decode_mag(s1_r.mb, s1_r.cfg.n, s1_r.cfg.es);
    s2_nxt.cfg  = s1_r.cfg;
    s2_nxt.spec = s1_r.spec;
    s2_nxt.neg  = s1_r.neg;
    s2_nxt.sa   = ha.scale;
    s2_nxt.sb   = hb.scale;
    s2_nxt.fa   = ha.frac;
    s2_nxt.fb   = hb.frac;
  end

  assign adv2 = !s2_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (adv2) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2 && s1_v_r) begin
      s2_r <= s2_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_data  = s2_r;

`include "posit_multiplier_top_defines.svh"

  `PM_ASSERT_IMP(a_inv_is_special, s2_v_r && s2_r.spec.invalid, s2_r.spec.hit, "invalid without special case")
  `PM_ASSERT_NXT(a_s1_hold, s1_v_r && !adv2, s1_v_r && $stable(s1_r), "stage one lost a stalled beat")

endmodule

// ----- rtl/core/pm_mul.sv -----
// Hidden-bit fraction multiply and scale sum (one stage).
module pm_mul (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  pm_pkg::pm_unp_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output pm_pkg::pm_prod_t out_data
);
  import pm_pkg::*;

  logic [PM_W-1:0]   xa;
  logic [PM_W-1:0]   xb;
  logic [2*PM_W-1:0] prod;
  pm_prod_t          m_nxt;
  pm_prod_t          m_r;
  logic              m_v_r;
  logic              adv;

  // Multiply the fractions with their hidden bits and keep the top word.
  always_comb begin
    xa          = {1'b1, in_data.fa[PM_W-1:1]};
    xb          = {1'b1, in_data.fb[PM_W-1:1]};
    prod        = {{PM_W{1'b0}}, xa} * {{PM_W{1'b0}}, xb};
    m_nxt.cfg   = in_data.cfg;
    m_nxt.spec  = in_data.spec;
    m_nxt.neg   = in_data.neg;
    m_nxt.raw1  = in_data.sa + in_data.sb + 12'sd1;
    m_nxt.m     = prod[2*PM_W-1:PM_W];
  end

  assign adv      = !m_v_r || out_ready;
  assign in_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (adv) begin
      m_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      m_r <= m_nxt;
    end
  end

  assign out_valid = m_v_r;
  assign out_data  = m_r;

endmodule

// ----- rtl/core/pm_pack.sv -----
// Normalization, scale clipping and posit encoding of the product (two stages).
module pm_pack (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  pm_pkg::pm_prod_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [31:0]      out_product,
  output logic             out_invalid
);
  import pm_pkg::*;

  // Stage A: normalize, clip the scale and split it into regime and exponent.
  logic                      shift;
  logic signed [SCALE_W-1:0] raw;
  logic signed [SCALE_W-1:0] rmax;
  logic signed [SCALE_W-1:0] rmin;
  logic signed [SCALE_W-1:0] rf;
  logic                      clip;
  pm_fmt_t                   a_nxt;
  pm_fmt_t                   a_r;
  logic                      a_v_r;
  logic                      adv_a;
  logic                      adv_b;

  always_comb begin
    shift = ~in_data.m[PM_W-1];
    raw   = in_data.raw1 - $signed({{(SCALE_W-1){1'b0}}, shift});
    rmax  = $signed({{(SCALE_W-6){1'b0}}, in_data.cfg.n - 6'd2}) <<< in_data.cfg.es;
    rmin  = -rmax;
    clip  = (raw < rmin) || (raw >= rmax);
    if (raw < rmin) begin
      rf = rmin;
    end else if (raw > rmax) begin
      rf = rmax;
    end else begin
      rf = raw;
    end
    a_nxt.cfg   = in_data.cfg;
    a_nxt.spec  = in_data.spec;
    a_nxt.neg   = in_data.neg;
    a_nxt.rreg  = REG_W'(rf >>> in_data.cfg.es);
    a_nxt.rexp  = rf[3:0] & ~(4'hF << in_data.cfg.es);
    a_nxt.rfrac = clip ? '0 : (in_data.m << (shift ? 2'd2 : 2'd1));
  end

  assign adv_a    = !a_v_r || adv_b;
  assign in_ready = adv_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (adv_a) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && in_valid) begin
      a_r <= a_nxt;
    end
  end

  // Stage B: assemble regime, exponent and fraction, apply sign, right align.
  logic signed [REG_W-1:0] t1;
  logic signed [REG_W-1:0] t2;
  logic signed [REG_W-1:0] rs;
  logic [PM_W-1:0]         regbits;
  logic [PM_W-1:0]         expbits;
  logic [PM_W-1:0]         body;
  logic [PM_W-1:0]         bits;
  logic [PM_W-1:0]         top;
  logic [PM_W-1:0]         r;
  logic [PM_W-1:0]         prod_nxt;
  logic [PM_W-1:0]         prod_r;
  logic                    inv_r;
  logic                    b_v_r;

  always_comb begin
    t1 = 7'sd1 - a_r.rreg;
    t2 = a_r.rreg + 7'sd2;
    rs = (t1 > t2) ? t1 : t2;
    if (a_r.rreg < 0) begin
      regbits = 32'h8000_0000 >> 6'(-a_r.rreg);
    end else begin
      regbits = 32'hFFFF_FFFF << 6'(7'sd31 - a_r.rreg);
    end
    expbits = {28'd0, a_r.rexp} << (6'd32 - {3'b000, a_r.cfg.es});
    body    = expbits | (a_r.rfrac >> a_r.cfg.es);
    bits    = (regbits | (body >> 6'(rs))) >> 1;
    if (a_r.neg) begin
      bits = ~bits + 32'd1;
    end
    top      = 32'hFFFF_FFFF << (6'd32 - a_r.cfg.n);
    r        = a_r.spec.hit ? a_r.spec.r : (bits & top);
    prod_nxt = a_r.spec.invalid ? '0 : (r >> (6'd32 - a_r.cfg.n));
  end

  assign adv_b = !b_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (adv_b) begin
      b_v_r <= a_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b && a_v_r) begin
      prod_r <= prod_nxt;
      inv_r  <= a_r.spec.invalid;
    end
  end

  assign out_valid   = b_v_r;
  assign out_product = prod_r;
  assign out_invalid = inv_r;

`include "posit_multiplier_top_defines.svh"

  `PM_ASSERT_IMP(a_inv_zero, b_v_r && inv_r, prod_r == '0, "invalid beat with nonzero product")
  `PM_ASSERT_IMP(a_rexp_range, a_v_r && !a_r.spec.hit, (a_r.rexp >> a_r.cfg.es) == 4'd0, "exponent field overflows es")
  `PM_ASSERT_NXT(a_stage_a_hold, a_v_r && !adv_b, a_v_r && $stable(a_r), "stage A lost a stalled beat")

endmodule

// ----- rtl/core/posit_multiplier_top.sv -----
// Top level of the pipelined posit multiplier.
// Multiplies two posits of word_bits (3..32) bits and exponent_bits (0..4) exponent bits,
// one operand beat per clock while the product side does not stall. The five pipeline
// registers are: operand alignment and special case detection, regime and fraction decode,
// the 32x32 fraction multiply, normalization and scale clipping, and the re-encoded output
// register. Stalls on the product side back up stage by stage, so empty stages keep taking
// beats. Write the configuration registers only while the pipeline is empty.
module posit_multiplier_top #(
  parameter int MAX_WORD_BITS = pm_pkg::MAX_WORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [pm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pm_pkg::CFG_DATA_W-1:0]  cfg_data,
  pm_in_if.sink                          in_beat,
  pm_out_if.source                       out_beat
);
  import pm_pkg::*;

  // Configuration registers.
  logic [5:0] word_bits_r;
  logic [2:0] exp_bits_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_bits_r <= WORD_BITS_RST;
      exp_bits_r  <= EXP_BITS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WORD_BITS: word_bits_r <= cfg_data[5:0];
        CFG_EXP_BITS:  exp_bits_r  <= cfg_data[2:0];
        default:       ;
      endcase
    end
  end

  // Pipeline sections.
  logic     unp_valid;
  logic     unp_ready;
  pm_unp_t  unp_data;
  logic     mul_valid;
  logic     mul_ready;
  pm_prod_t mul_data;

  pm_unpack #(
    .MAX_WORD_BITS(MAX_WORD_BITS)
  ) u_unpack (
    .clk       (clk),
    .rst_n     (rst_n),
    .word_bits (word_bits_r),
    .exp_bits  (exp_bits_r),
    .in_valid  (in_beat.valid),
    .in_ready  (in_beat.ready),
    .operand_a (in_beat.operand_a),
    .operand_b (in_beat.operand_b),
    .out_valid (unp_valid),
    .out_ready (unp_ready),
    .out_data  (unp_data)
  );

  pm_mul u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (unp_valid),
    .in_ready  (unp_ready),
    .in_data   (unp_data),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .out_data  (mul_data)
  );

  pm_pack u_pack (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (mul_valid),
    .in_ready    (mul_ready),
    .in_data     (mul_data),
    .out_valid   (out_beat.valid),
    .out_ready   (out_beat.ready),
    .out_product (out_beat.product),
    .out_invalid (out_beat.invalid)
  );

endmodule
